/* rtl/probe_contact_trigger_detector_defines.svh */
// Assertion macros used by the detector top level
`ifndef PROBE_CONTACT_TRIGGER_DETECTOR_DEFINES_SVH
`define PROBE_CONTACT_TRIGGER_DETECTOR_DEFINES_SVH

// Check a condition at every clock edge out of reset
`define PCTD_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define PCTD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* rtl/pctd_pkg.sv */
// Constants, types and codes of the probe contact trigger detector
package pctd_pkg;

	localparam int WINDOW     = 10;
	localparam int RDW        = 28;
	localparam int DW         = RDW + 1;
	localparam int IDXW       = $clog2(WINDOW);
	localparam int POSW       = $clog2(WINDOW + 1);
	localparam int SUMW       = DW + $clog2(WINDOW);
	localparam int MAGW       = SUMW - 1;
	localparam int DIVW       = MAGW;
	localparam int RCPW       = DIVW + 1;
	localparam int RCP_SH     = DIVW + $clog2(WINDOW);
	localparam int PRODW      = DIVW + RCPW;
	localparam int CMPW       = DW + 2;
	localparam int PEAK_FLOOR = 100;
	localparam int IN_TDW     = 32;
	localparam int OUT_TDW    = 8;
	localparam int CFG_IW     = 3;

	localparam logic [RCPW-1:0] RECIP =
		RCPW'(((64'd1 << RCP_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

	localparam logic [RDW-1:0] TRIG_LVL_RST  = RDW'(33784425);
	localparam logic [RDW-1:0] REL_LVL_RST   = RDW'(33581718);
	localparam logic [RDW-1:0] SLOPE_THR_RST = RDW'(1000);

	typedef enum logic [CFG_IW-1:0] {
		CFG_ARMED      = 3'd0,
		CFG_SLOPE_MODE = 3'd1,
		CFG_TRIG_LVL   = 3'd2,
		CFG_REL_LVL    = 3'd3,
		CFG_SLOPE_THR  = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

	typedef struct packed {
		logic            start;
		logic [DIVW-1:0] mag;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [DIVW-1:0] quo;
	} div_rsp_t;

endpackage

/* rtl/pctd_cell.sv */
// One ring cell: holds a delta, loads a new one or takes its neighbor's
module pctd_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pctd_pkg::cell_ctl_t              ctl,
	input  logic signed [pctd_pkg::DW-1:0]   nbr,
	input  logic signed [pctd_pkg::DW-1:0]   load_val,
	output logic signed [pctd_pkg::DW-1:0]   val
);
	import pctd_pkg::*;

	logic signed [DW-1:0] val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (ctl.load) begin
			val_q <= load_val;
		end else if (ctl.shift) begin
			val_q <= nbr;
		end
	end

	assign val = val_q;

endmodule

/* rtl/pctd_div.sv */
// Divider of a magnitude by the window length: the magnitude is registered, then multiplied by the reciprocal
module pctd_div (
	input  logic                clk,
	input  logic                arst_n,
	input  pctd_pkg::div_req_t  req,
	output pctd_pkg::div_rsp_t  rsp
);
	import pctd_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [DIVW-1:0]  mag_q;
	logic [PRODW-1:0] prod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= req.start;
			done_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mag_q <= req.mag;
		end
		if (busy_q) begin
			prod_q <= PRODW'(mag_q) * PRODW'(RECIP);
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = DIVW'(prod_q[PRODW-1:RCP_SH]);

endmodule

/* rtl/probe_contact_trigger_detector.sv */
// Top level of the probe contact trigger detector
//
//  port group | role            | payload
//  s_axis     | sensor items    | tdata: reading; tuser: req_type
//  m_axis     | result items    | tdata: triggered, indicator
//  cfg        | register writes | cfg_index, cfg_data
//
// An item that forms no average is accepted, then its result is issued. An
// averaging item rotates the cell ring through the accumulator, then the divider
// multiplies the sum's magnitude by the reciprocal of WINDOW. One item is worked
// at a time. A result waiting on m_axis does not block acceptance of the next
// item, but that item's result waits until the held one is taken. Reset clears
// all state but the divider's operand and product; ring cells included, no clearing pass.
`include "probe_contact_trigger_detector_defines.svh"

module probe_contact_trigger_detector (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [pctd_pkg::IN_TDW-1:0]      s_axis_tdata,   // [27:0] reading
	input  logic                             s_axis_tuser,   // [0] req_type
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [pctd_pkg::OUT_TDW-1:0]     m_axis_tdata,   // [0] triggered, [1] indicator
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pctd_pkg::CFG_IW-1:0]      cfg_index,
	input  logic [pctd_pkg::RDW-1:0]         cfg_data
);
	import pctd_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SUM  = 6'b000010,
		ST_ABS  = 6'b000100,
		ST_WAIT = 6'b001000,
		ST_CMP  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t               st_q;
	logic                 armed_q;
	logic                 slope_q;
	logic [RDW-1:0]       trig_lvl_q;
	logic [RDW-1:0]       rel_lvl_q;
	logic [RDW-1:0]       slope_thr_q;
	logic [RDW-1:0]       baseline_q;
	logic [POSW-1:0]      ring_pos_q;
	logic                 primed_q;
	logic signed [DW-1:0] peak_q;
	logic                 ind_q;
	logic                 trig_q;
	logic signed [SUMW-1:0] acc_q;
	logic [IDXW-1:0]      cnt_q;
	logic                 neg_q;
	logic                 m_valid_q;
	logic [1:0]           m_data_q;

	logic                 in_acc;
	logic                 req;
	logic [RDW-1:0]       rd;
	logic signed [DW-1:0] delta;
	logic                 at_end;
	logic [IDXW-1:0]      wr_slot;
	logic                 slope_go;
	logic                 avg_go;
	logic                 level_trig;
	logic [MAGW-1:0]      mag_v;
	logic signed [SUMW-1:0] neg_acc;
	logic signed [DW-1:0] avg;
	logic [DW-1:0]        quo_v;
	logic signed [CMPW-1:0] thr_sum;
	logic                 fire;
	logic                 out_free;

	logic signed [DW-1:0] cell_val [WINDOW];
	cell_ctl_t            cell_ctl [WINDOW];
	div_req_t             div_req;
	div_rsp_t             div_rsp;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (st_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign req           = s_axis_tuser;
	assign rd            = s_axis_tdata[RDW-1:0];
	assign delta         = $signed({1'b0, rd}) - $signed({1'b0, baseline_q});
	assign at_end        = (ring_pos_q == POSW'(WINDOW));
	assign wr_slot       = at_end ? '0 : ring_pos_q[IDXW-1:0];
	assign slope_go      = in_acc && !req && armed_q && slope_q && (baseline_q != '0);
	assign avg_go        = slope_go && (at_end || primed_q);
	assign level_trig    = armed_q && !slope_q && (rd != '0) && (rd > trig_lvl_q);

	generate
		for (genvar i = 0; i < WINDOW; i++) begin : g_ring
			assign cell_ctl[i].shift = (st_q == ST_SUM);
			assign cell_ctl[i].load  = slope_go && (wr_slot == IDXW'(i));
			pctd_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (cell_ctl[i]),
				.nbr      (cell_val[(i + 1) % WINDOW]),
				.load_val (delta),
				.val      (cell_val[i])
			);
		end
	endgenerate

	assign neg_acc     = -acc_q;
	assign mag_v       = acc_q[SUMW-1] ? neg_acc[MAGW-1:0] : acc_q[MAGW-1:0];
	assign div_req.start = (st_q == ST_ABS);
	assign div_req.mag   = DIVW'(mag_v);

	pctd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign quo_v   = div_rsp.quo[DW-1:0];
	assign avg     = neg_q ? -$signed(quo_v) : $signed(quo_v);
	assign thr_sum = $signed({2'b00, 1'b0, slope_thr_q}) + CMPW'(avg);
	assign fire    = (CMPW'(peak_q) > thr_sum) && (peak_q > $signed(DW'(PEAK_FLOOR)));
	assign out_free = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q     <= 1'b0;
			slope_q     <= 1'b0;
			trig_lvl_q  <= TRIG_LVL_RST;
			rel_lvl_q   <= REL_LVL_RST;
			slope_thr_q <= SLOPE_THR_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ARMED:      armed_q     <= cfg_data[0];
				CFG_SLOPE_MODE: slope_q     <= cfg_data[0];
				CFG_TRIG_LVL:   trig_lvl_q  <= cfg_data;
				CFG_REL_LVL:    rel_lvl_q   <= cfg_data;
				CFG_SLOPE_THR:  slope_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			baseline_q <= '0;
			ring_pos_q <= '0;
			primed_q   <= 1'b0;
			peak_q     <= '0;
			ind_q      <= 1'b0;
			trig_q     <= 1'b0;
			acc_q      <= '0;
			cnt_q      <= '0;
			neg_q      <= 1'b0;
			m_valid_q  <= 1'b0;
			m_data_q   <= '0;
		end else begin
			if (m_valid_q && m_axis_tready && st_q != ST_OUT) begin
				m_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						acc_q  <= '0;
						cnt_q  <= '0;
						st_q   <= avg_go ? ST_SUM : ST_OUT;
						if (req) begin
							trig_q     <= 1'b0;
							baseline_q <= '0;
							ring_pos_q <= '0;
							primed_q   <= 1'b0;
							peak_q     <= '0;
						end else begin
							trig_q <= level_trig;
							if (rd != '0) begin
								if (rd > trig_lvl_q) begin
									ind_q <= 1'b1;
								end else if (rd < rel_lvl_q) begin
									ind_q <= 1'b0;
								end
							end
							if (armed_q && slope_q) begin
								baseline_q <= rd;
								if (slope_go) begin
									ring_pos_q <= POSW'(wr_slot) + POSW'(1);
									primed_q   <= primed_q || at_end;
								end
							end
						end
					end
				end
				ST_SUM: begin
					acc_q <= acc_q + SUMW'(cell_val[0]);
					cnt_q <= cnt_q + IDXW'(1);
					if (cnt_q == IDXW'(WINDOW - 1)) begin
						st_q <= ST_ABS;
					end
				end
				ST_ABS: begin
					neg_q <= acc_q[SUMW-1];
					st_q  <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_rsp.done) begin
						st_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (fire) begin
						trig_q     <= 1'b1;
						baseline_q <= '0;
						ring_pos_q <= '0;
						primed_q   <= 1'b0;
						peak_q     <= '0;
					end else if (avg > peak_q) begin
						peak_q <= avg;
					end
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {ind_q, trig_q};
						st_q      <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_TDW'(m_data_q);

	`PCTD_ASSERT_ALWAYS(a_pos_range, ring_pos_q <= POSW'(WINDOW), "ring position past window")
	`PCTD_ASSERT_ALWAYS(a_peak_nonneg, !peak_q[DW-1], "peak average went negative")
	`PCTD_ASSERT_IMPLIES(a_primed_pos, primed_q, ring_pos_q != '0, "primed with empty position")
	`PCTD_ASSERT_IMPLIES(a_div_done, div_rsp.done, st_q == ST_WAIT, "divider done out of wait")

endmodule
